// File: sv/pxup_pkg.sv
`default_nettype none
package pxup_pkg;

    localparam int SRC_WIDTH  = 160;
    localparam int OUT_HEIGHT = 216;
    localparam int FB_WIDTH   = 320;
    localparam int FB_HEIGHT  = 240;
    localparam int SRC_ROWS   = (2 * (OUT_HEIGHT - 1)) / 3 + 1;

    localparam int CNT_W  = 8;   // source column / row counters
    localparam int OUT_W  = 10;  // scaled window coordinates
    localparam int FBC_W  = 11;  // framebuffer coordinates
    localparam int ADDR_W = 17;
    localparam int PIX_W  = 16;
    localparam int XOFF_W = 7;
    localparam int YOFF_W = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register indexes on the config port
    localparam logic REG_X_OFFSET = 1'b0;
    localparam logic REG_Y_OFFSET = 1'b1;

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(FB_WIDTH);

    typedef struct packed {
        logic [XOFF_W-1:0] x_offset;
        logic [YOFF_W-1:0] y_offset;
    } pxup_cfg_t;

    // one source pixel after classification: write mask bit order is
    // (row0,col0), (row0,col1), (row1,col0), (row1,col1)
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [ADDR_W-1:0] base;
        logic [3:0]        mask;
    } pxup_desc_t;

endpackage
`default_nettype wire

// File: sv/pxup_front.sv
`default_nettype none
module pxup_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pxup_pkg::pxup_cfg_t         cfg,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [pxup_pkg::PIX_W-1:0]  pixel_value,
    input  wire logic                        frame_start,
    input  wire logic                        q_full,
    output logic                             q_push,
    output pxup_pkg::pxup_desc_t             q_data
);
    import pxup_pkg::*;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] c, r;
    logic [OUT_W-1:0] x0, y0;
    logic [FBC_W-1:0] fx0, fx1, fy0, fy1;
    logic [OUT_W-1:0] oy1;
    logic             col_ok0, col_ok1, row_ok0, row_ok1;
    logic [3:0]       mask;
    logic [31:0]      base_full;
    logic             accept;
    logic [CNT_W:0]   col_inc, row_inc;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign c = frame_start ? '0 : col_reg;
    assign r = frame_start ? '0 : row_reg;

    // first output coordinate: s + s/2, plus one for odd s
    assign x0 = OUT_W'(c) + OUT_W'(c >> 1) + OUT_W'(c[0]);
    assign y0 = OUT_W'(r) + OUT_W'(r >> 1) + OUT_W'(r[0]);

    assign fx0 = FBC_W'(x0) + FBC_W'(cfg.x_offset);
    assign fx1 = fx0 + FBC_W'(1);
    assign fy0 = FBC_W'(y0) + FBC_W'(cfg.y_offset);
    assign fy1 = fy0 + FBC_W'(1);
    assign oy1 = y0 + OUT_W'(1);

    assign col_ok0 = 32'(fx0) < FB_WIDTH;
    assign col_ok1 = (32'(fx1) < FB_WIDTH) && !c[0];
    assign row_ok0 = (32'(y0) < OUT_HEIGHT) && (32'(fy0) < FB_HEIGHT);
    assign row_ok1 = (32'(oy1) < OUT_HEIGHT) && (32'(fy1) < FB_HEIGHT) && !r[0];

    assign mask = {row_ok1 & col_ok1, row_ok1 & col_ok0,
                   row_ok0 & col_ok1, row_ok0 & col_ok0};

    assign base_full = 32'(fy0) * 32'(FB_WIDTH) + 32'(fx0);

    assign q_push      = accept && (mask != 4'b0000);
    assign q_data.pix  = pixel_value;
    assign q_data.base = base_full[ADDR_W-1:0];
    assign q_data.mask = mask;

    assign col_inc = {1'b0, c} + 1'b1;
    assign row_inc = {1'b0, r} + 1'b1;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (32'(col_inc) >= SRC_WIDTH)
            begin
                col_next = '0;
                row_next = (32'(row_inc) >= SRC_ROWS) ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/pxup_queue.sv
`default_nettype none
module pxup_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire pxup_pkg::pxup_desc_t  push_data,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       head_valid,
    output pxup_pkg::pxup_desc_t       head_data
);
    import pxup_pkg::*;

    pxup_desc_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (32'(count_reg) == QUEUE_DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/pxup_back.sv
`default_nettype none
module pxup_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire pxup_pkg::pxup_desc_t         q_data,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [pxup_pkg::ADDR_W-1:0]       fb_address,
    output logic [pxup_pkg::PIX_W-1:0]        fb_pixel,
    output logic                              run_last
);
    import pxup_pkg::*;

    logic              cur_valid_reg, cur_valid_next;
    pxup_desc_t        cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic              last_reg, last_next;
    logic              load;
    logic [3:0]        pick;
    logic [3:0]        remain;
    logic [ADDR_W-1:0] step;

    assign load = cur_valid_reg && (!out_valid_reg || !out_stall);

    // lowest pending write goes out first
    assign pick   = cur_reg.mask & (~cur_reg.mask + 4'b0001);
    assign remain = cur_reg.mask & ~pick;

    always_comb
    begin
        case (pick)
            4'b0001: step = '0;
            4'b0010: step = ADDR_W'(1);
            4'b0100: step = ROW_STEP;
            4'b1000: step = ROW_STEP + ADDR_W'(1);
            default: step = '0;
        endcase
    end

    assign q_pop = q_valid && (!cur_valid_reg || (load && remain == 4'b0000));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (load)
        begin
            cur_next.mask  = remain;
            cur_valid_next = (remain != 4'b0000);
        end
        if (q_pop)
        begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg && out_stall;
        addr_next      = addr_reg;
        pix_next       = pix_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            addr_next      = cur_reg.base + step;
            pix_next       = cur_reg.pix;
            last_next      = (remain == 4'b0000);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        addr_reg <= addr_next;
        pix_reg  <= pix_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign fb_address = addr_reg;
    assign fb_pixel   = pix_reg;
    assign run_last   = last_reg;

endmodule
`default_nettype wire

// File: sv/pixel_upscale_3_2_writer.sv
// A write goes from its queue entry through the current-item register to the
//   output register; one framebuffer write per cycle leaves while out_stall is low.
//   An item yields 1 to 4 writes; an item with none is never queued.
// A four-entry queue between classifier and write sequencer absorbs output stalls.
// Reset (rst_n low, asynchronous) clears counters, queue and output valid;
//   x_offset returns to 40 and y_offset to 12.
`default_nettype none
module pixel_upscale_3_2_writer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [pxup_pkg::PIX_W-1:0]   pixel_value,
    input  wire logic                         frame_start,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [pxup_pkg::ADDR_W-1:0]       fb_address,
    output logic [pxup_pkg::PIX_W-1:0]        fb_pixel,
    output logic                              run_last
);
    import pxup_pkg::*;

    pxup_cfg_t  cfg_reg, cfg_next;
    logic       cfg_write;
    logic       q_full, q_push, q_pop, q_valid;
    pxup_desc_t q_in, q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_X_OFFSET: cfg_next.x_offset = pwdata[XOFF_W-1:0];
                REG_Y_OFFSET: cfg_next.y_offset = pwdata[YOFF_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_X_OFFSET: prdata = 32'(cfg_reg.x_offset);
            REG_Y_OFFSET: prdata = 32'(cfg_reg.y_offset);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset <= XOFF_W'(40);
            cfg_reg.y_offset <= YOFF_W'(12);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pxup_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .frame_start (frame_start),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    pxup_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    pxup_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .fb_address (fb_address),
        .fb_pixel   (fb_pixel),
        .run_last   (run_last)
    );

endmodule
`default_nettype wire
